FILE: rtl/f2dtxt_pkg.sv
// Package for the float-to-decimal-text block: widths, character codes and
// the status record of the binary-to-BCD converter. No dependencies.
`timescale 1ns / 1ps

package f2dtxt_pkg;

  localparam int FRACTION_DIGITS = 5;  // 1..9
  localparam int FRAC_CNT_W      = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;

  localparam int FLOAT_W   = 32;
  localparam int EXP_W     = 8;
  localparam int MAN_W     = 24;            // mantissa with the implicit one
  localparam int FRAC_W    = 64;            // fraction kept as a 64-bit binary fraction
  localparam int SHIFT_W   = 6;             // shifts of 64 and up give zero
  localparam int ALIGN_W   = MAN_W + FRAC_W;

  localparam logic [EXP_W-1:0] EXP_MAX = 8'd150;  // exponent where the shift is zero

  localparam int INT_DIGITS    = 8;         // 2^24 - 1 has eight decimal digits
  localparam int INT_IDX_W     = 3;
  localparam int BCD_W         = 4 * INT_DIGITS;
  localparam int BITS_PER_STEP = 4;
  localparam int BCD_STEPS     = MAN_W / BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(BCD_STEPS);

  localparam logic [7:0] CH_NONE  = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse, BCD result valid
  } bcd_stat_t;

endpackage

FILE: rtl/f2dtxt_in_if.sv
// Request channel carrying one single-precision bit pattern.
// Depends on f2dtxt_pkg.
`timescale 1ns / 1ps

interface f2dtxt_in_if;
  logic                          valid;
  logic                          ready;
  logic [f2dtxt_pkg::FLOAT_W-1:0] float_bits;

  modport source (output valid, output float_bits, input ready);
  modport sink   (input valid, input float_bits, output ready);
endinterface

FILE: rtl/f2dtxt_out_if.sv
// Result channel carrying one text character per transfer.
// No package dependency.
`timescale 1ns / 1ps

interface f2dtxt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  logic       out_of_range;

  modport source (output valid, output character, output last, output out_of_range,
                  input ready);
  modport sink   (input valid, input character, input last, input out_of_range,
                  output ready);
endinterface

FILE: rtl/float_to_fixed_decimal_text_core.sv
// Top level: single-precision bit pattern to fixed-point decimal ASCII text.
// Depends on f2dtxt_pkg, f2dtxt_in_if, f2dtxt_out_if and f2dtxt_bcd.
`timescale 1ns / 1ps
//
// Usage:
//   din  : one request per float pattern (valid/ready, float_bits).
//   dout : the text, one character per transfer: optional '-', integer digits,
//          '.', then FRACTION_DIGITS truncated fraction digits; last marks the
//          final character. Exponents above 150 (|x| >= 2^24, Inf, NaN) give a
//          single transfer with character 0, last and out_of_range set.
//   Timing: the integer part goes through a shift/add-3 converter that
//   handles four bits a cycle of the 24-bit mantissa. Fraction digits come
//   from one 68-bit times-ten adder, one digit per character. din.ready is
//   high only while no request is in work.
//   A stalled dout holds the current character and the sequencer waits; the
//   output register lets the next request be taken while the final character
//   of the previous one is still waiting.
//   Reset (rst, synchronous) drops any request in work and clears dout.valid.

module float_to_fixed_decimal_text_core (
  input  logic          clk,
  input  logic          rst,
  f2dtxt_in_if.sink     din,
  f2dtxt_out_if.source  dout
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CONV = 7'b0000010,
    S_SIGN = 7'b0000100,
    S_INT  = 7'b0001000,
    S_DOT  = 7'b0010000,
    S_FRAC = 7'b0100000,
    S_OOR  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic                                  sign;
  logic [f2dtxt_pkg::FRAC_W-1:0]         frac;
  logic [f2dtxt_pkg::INT_IDX_W-1:0]      int_idx;
  logic [f2dtxt_pkg::FRAC_CNT_W-1:0]     frac_cnt;
  logic                                  bcd_start;
  f2dtxt_pkg::bcd_stat_t                 bcd_stat;
  logic [f2dtxt_pkg::BCD_W-1:0]          bcd;

  // load-time decode
  logic [f2dtxt_pkg::EXP_W-1:0]          expo;
  logic [f2dtxt_pkg::EXP_W-1:0]          shift;
  logic                                  in_oor;
  logic [f2dtxt_pkg::ALIGN_W-1:0]        aligned;
  logic                                  in_fire;

  // emit path
  logic                                  out_free;
  logic                                  emit;
  logic [7:0]                            ch;
  logic                                  ch_last;
  logic                                  ch_oor;
  logic [f2dtxt_pkg::FRAC_W+3:0]         times10;
  logic [3:0]                            int_nib;
  logic [f2dtxt_pkg::INT_IDX_W-1:0]      top_idx;

  assign din.ready = (state == S_IDLE);
  assign in_fire   = din.valid && din.ready;

  assign expo   = din.float_bits[30:23];
  assign in_oor = expo > f2dtxt_pkg::EXP_MAX;
  assign shift  = f2dtxt_pkg::EXP_MAX - expo;

  // {mantissa, 64 fraction bits} >> shift: integer part on top, binary fraction below
  always_comb begin
    if (shift[7:6] != 2'b00) begin
      aligned = '0;
    end else begin
      aligned = {1'b1, din.float_bits[22:0], {f2dtxt_pkg::FRAC_W{1'b0}}}
                >> shift[f2dtxt_pkg::SHIFT_W-1:0];
    end
  end

  assign bcd_start = in_fire && !in_oor;

  f2dtxt_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (bcd_start),
    .value (aligned[f2dtxt_pkg::ALIGN_W-1:f2dtxt_pkg::FRAC_W]),
    .stat  (bcd_stat),
    .bcd   (bcd)
  );

  // highest nonzero BCD digit; zero selects the single '0'
  always_comb begin
    top_idx = '0;
    for (int d = 1; d < f2dtxt_pkg::INT_DIGITS; d++) begin
      if (bcd[4*d +: 4] != 4'd0) begin
        top_idx = f2dtxt_pkg::INT_IDX_W'(d);
      end
    end
  end

  assign times10 = {1'b0, frac, 3'b000} + {3'b000, frac, 1'b0};
  assign int_nib = bcd[{int_idx, 2'b00} +: 4];

  assign out_free = !dout.valid || dout.ready;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    ch         = f2dtxt_pkg::CH_NONE;
    ch_last    = 1'b0;
    ch_oor     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = in_oor ? S_OOR : S_CONV;
        end
      end
      S_CONV: begin
        if (bcd_stat.done) begin
          state_next = sign ? S_SIGN : S_INT;
        end
      end
      S_SIGN: begin
        emit = out_free;
        ch   = f2dtxt_pkg::CH_MINUS;
        if (out_free) state_next = S_INT;
      end
      S_INT: begin
        emit = out_free;
        ch   = f2dtxt_pkg::CH_ZERO | {4'b0000, int_nib};
        if (out_free && int_idx == '0) state_next = S_DOT;
      end
      S_DOT: begin
        emit = out_free;
        ch   = f2dtxt_pkg::CH_DOT;
        if (out_free) state_next = S_FRAC;
      end
      S_FRAC: begin
        emit    = out_free;
        ch      = f2dtxt_pkg::CH_ZERO | {4'b0000, times10[f2dtxt_pkg::FRAC_W+3:f2dtxt_pkg::FRAC_W]};
        ch_last = (frac_cnt == '0);
        if (out_free && frac_cnt == '0) state_next = S_IDLE;
      end
      S_OOR: begin
        emit    = out_free;
        ch      = f2dtxt_pkg::CH_NONE;
        ch_last = 1'b1;
        ch_oor  = 1'b1;
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      dout.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        dout.valid <= 1'b1;
      end else if (dout.ready) begin
        dout.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sign <= din.float_bits[31];
      frac <= aligned[f2dtxt_pkg::FRAC_W-1:0];
    end
    if (state == S_CONV && bcd_stat.done) begin
      int_idx <= top_idx;
    end else if (state == S_INT && out_free) begin
      int_idx <= int_idx - 1'b1;
    end
    if (state == S_DOT && out_free) begin
      frac_cnt <= f2dtxt_pkg::FRAC_CNT_W'(f2dtxt_pkg::FRACTION_DIGITS - 1);
    end else if (state == S_FRAC && out_free) begin
      frac_cnt <= frac_cnt - 1'b1;
      frac     <= times10[f2dtxt_pkg::FRAC_W-1:0];
    end
    if (emit) begin
      dout.character    <= ch;
      dout.last         <= ch_last;
      dout.out_of_range <= ch_oor;
    end
  end

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state != S_IDLE)
    else $error("request accepted but sequencer idle");
  a_conv_handoff: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV && bcd_stat.done) |=> (state == S_SIGN || state == S_INT))
    else $error("converter done not followed by emission");
  a_conv_running: assert property (@(posedge clk) disable iff (rst)
    state == S_CONV |-> (bcd_stat.busy || bcd_stat.done))
    else $error("waiting on an idle converter");
  a_oor_form: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.out_of_range) |-> (dout.last && dout.character == f2dtxt_pkg::CH_NONE))
    else $error("malformed out-of-range result");

endmodule

FILE: rtl/f2dtxt_bcd.sv
// Iterative binary to BCD converter (shift and add-3), four bits per cycle.
// Depends on f2dtxt_pkg.
`timescale 1ns / 1ps

module f2dtxt_bcd (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [f2dtxt_pkg::MAN_W-1:0]     value,
  output f2dtxt_pkg::bcd_stat_t            stat,
  output logic [f2dtxt_pkg::BCD_W-1:0]     bcd
);

  logic [f2dtxt_pkg::MAN_W-1:0]      bin;
  logic [f2dtxt_pkg::MAN_W-1:0]      bin_next;
  logic [f2dtxt_pkg::BCD_W-1:0]      acc;
  logic [f2dtxt_pkg::BCD_W-1:0]      acc_next;
  logic [f2dtxt_pkg::STEP_CNT_W-1:0] cnt;
  logic                              busy;
  logic                              done;

  always_comb begin
    logic [f2dtxt_pkg::BCD_W-1:0] a;
    logic [f2dtxt_pkg::MAN_W-1:0] b;
    a = acc;
    b = bin;
    for (int s = 0; s < f2dtxt_pkg::BITS_PER_STEP; s++) begin
      for (int d = 0; d < f2dtxt_pkg::INT_DIGITS; d++) begin
        if (a[4*d +: 4] >= 4'd5) begin
          a[4*d +: 4] = a[4*d +: 4] + 4'd3;
        end
      end
      {a, b} = {a[f2dtxt_pkg::BCD_W-2:0], b, 1'b0};
    end
    acc_next = a;
    bin_next = b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == f2dtxt_pkg::STEP_CNT_W'(f2dtxt_pkg::BCD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      acc <= '0;
    end else if (busy) begin
      bin <= bin_next;
      acc <= acc_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign bcd       = acc;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("bcd start while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("bcd done without a finished run");

endmodule

FILE: tb/tb_f2dtxt_checker.sv
// Checker for the float-to-decimal-text core: watches both channels, predicts
// the text of every accepted request and compares each character.
// Depends on f2dtxt_pkg, f2dtxt_in_if and f2dtxt_out_if.
`timescale 1ns / 1ps

module tb_f2dtxt_checker (
  input  logic   clk,
  input  logic   rst,
  f2dtxt_in_if   din,
  f2dtxt_out_if  dout,
  output int     errors,
  output int     pending,
  output int     chars_seen,
  output int     oor_seen
);

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       out_of_range;
  } text_char_t;

  text_char_t text_fifo[$];

  // Appends the expected characters of one float pattern to text_fifo.
  function automatic void predict_text(input logic [f2dtxt_pkg::FLOAT_W-1:0] bits);
    logic [f2dtxt_pkg::EXP_W-1:0] expo;
    logic [63:0]      man;
    logic [63:0]      ipart;
    logic [63:0]      fpart;
    logic [63:0]      fdig;
    logic [63:0]      scale;
    int               shift;
    logic [7:0]       txt[$];
    logic [7:0]       digs[$];
    text_char_t       c;
    expo  = bits[30:23];
    ipart = '0;
    fdig  = '0;
    if (expo > f2dtxt_pkg::EXP_MAX) begin
      c = '{character: f2dtxt_pkg::CH_NONE, last: 1'b1, out_of_range: 1'b1};
      text_fifo.push_back(c);
      return;
    end
    shift = int'(f2dtxt_pkg::EXP_MAX) - int'(expo);
    man   = {40'd0, 1'b1, bits[22:0]};
    scale = 64'd1;
    for (int k = 0; k < f2dtxt_pkg::FRACTION_DIGITS; k++) scale = scale * 64'd10;
    // shifts of 64 and up leave both parts at zero
    if (shift < 64) begin
      ipart = man >> shift;
      fpart = man & ((64'd1 << shift) - 64'd1);
      fdig  = (fpart * scale) >> shift;
    end
    if (bits[31]) txt.push_back(f2dtxt_pkg::CH_MINUS);
    if (ipart == 0) begin
      txt.push_back(f2dtxt_pkg::CH_ZERO);
    end else begin
      while (ipart != 0) begin
        digs.push_front(f2dtxt_pkg::CH_ZERO + 8'(ipart % 64'd10));
        ipart = ipart / 64'd10;
      end
      foreach (digs[i]) txt.push_back(digs[i]);
    end
    txt.push_back(f2dtxt_pkg::CH_DOT);
    digs.delete();
    for (int k = 0; k < f2dtxt_pkg::FRACTION_DIGITS; k++) begin
      digs.push_front(f2dtxt_pkg::CH_ZERO + 8'(fdig % 64'd10));
      fdig = fdig / 64'd10;
    end
    foreach (digs[i]) txt.push_back(digs[i]);
    foreach (txt[i]) begin
      c = '{character: txt[i], last: (i == txt.size() - 1), out_of_range: 1'b0};
      text_fifo.push_back(c);
    end
  endfunction

  initial begin
    errors     = 0;
    pending    = 0;
    chars_seen = 0;
    oor_seen   = 0;
  end

  always @(posedge clk) begin
    text_char_t want;
    text_char_t got;
    if (!rst) begin
      // compare first so a request taken at this edge cannot hide a stray result
      if (dout.valid && dout.ready) begin
        got = '{character: dout.character, last: dout.last,
                out_of_range: dout.out_of_range};
        chars_seen <= chars_seen + 1;
        if (got.out_of_range) oor_seen <= oor_seen + 1;
        if (text_fifo.size() == 0) begin
          if (errors < 10)
            $display("unexpected character %02h last=%0b oor=%0b at %0t",
                     got.character, got.last, got.out_of_range, $realtime);
          errors <= errors + 1;
        end else begin
          want = text_fifo.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display({"mismatch at %0t: expected %02h last=%0b oor=%0b, ",
                        "got %02h last=%0b oor=%0b"},
                       $realtime, want.character, want.last, want.out_of_range,
                       got.character, got.last, got.out_of_range);
            errors <= errors + 1;
          end
        end
      end
      if (din.valid && din.ready) predict_text(din.float_bits);
      pending <= text_fifo.size();
    end
  end

endmodule

FILE: tb/tb_float_to_fixed_decimal_text_core.sv
// Testbench top for float_to_fixed_decimal_text_core: drives float patterns
// with random gaps and stalls, and reports the verdict from tb_f2dtxt_checker.
// Depends on f2dtxt_pkg, the two channel interfaces and the checker.
`timescale 1ns / 1ps

module tb_float_to_fixed_decimal_text_core;

  localparam int RANDOM_REQS = 407;
  localparam int IDLE_LIMIT  = 500;
  localparam int N_DIRECTED  = 23;

  localparam logic [31:0] DIRECTED [N_DIRECTED] = '{
    32'h0000_0000, 32'h8000_0000, 32'h007F_FFFF, 32'h3F80_0000, 32'hBF80_0000,
    32'h3FC0_0000, 32'h3F7F_FFFF, 32'h3DCC_CCCD, 32'h42F6_E979, 32'h4120_0000,
    32'h4B00_0000, 32'h4B7F_FFFF, 32'hCB7F_FFFF, 32'h4B80_0000, 32'h7F80_0000,
    32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h2B80_0000, 32'hAB7F_FFFF,
    32'h2BFF_FFFF, 32'h3400_0000, 32'h3727_C5AC
  };

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   chars_seen;
  int   oor_seen;
  int   reqs_sent;
  int   idle_cycles;
  bit   src_calm;
  bit   snk_calm;

  f2dtxt_in_if  din ();
  f2dtxt_out_if dout ();

  float_to_fixed_decimal_text_core i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  tb_f2dtxt_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .dout       (dout),
    .errors     (errors),
    .pending    (pending),
    .chars_seen (chars_seen),
    .oor_seen   (oor_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random pattern, weighted toward exponents that give many digits.
  function automatic logic [31:0] pick_pattern();
    int          r;
    logic [7:0]  e;
    logic [22:0] m;
    r = $urandom_range(0, 99);
    m = 23'($urandom);
    if ($urandom_range(0, 7) == 0) m = $urandom_range(0, 1) ? '1 : '0;
    if (r < 15)      return $urandom;
    else if (r < 50) e = 8'($urandom_range(120, 150));
    else if (r < 70) e = 8'($urandom_range(100, 150));
    else if (r < 80) e = 8'($urandom_range(151, 255));
    else if (r < 90) e = 8'($urandom_range(0, 99));
    else             e = 8'($urandom_range(140, 150));
    return {1'($urandom_range(0, 1)), e, m};
  endfunction

  task automatic send_request(input logic [31:0] bits);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      din.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    din.valid      = 1'b1;
    din.float_bits = bits;
    do @(posedge clk); while (!din.ready);
    reqs_sent++;
    @(negedge clk);
  endtask

  // result side: ready drops for a random stall before each character
  initial begin
    int stall;
    int n;
    dout.ready = 1'b0;
    snk_calm   = 1'b0;
    n          = 0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (n % 50 == 0) snk_calm = ($urandom_range(0, 3) == 0);
      stall = snk_calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        dout.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      dout.ready = 1'b1;
      do @(posedge clk); while (!dout.valid);
      n++;
      @(negedge clk);
    end
  end

  // nothing accepted on either side for too long ends the run
  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request or character moved for %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    din.valid      = 1'b0;
    din.float_bits = '0;
    reqs_sent      = 0;
    idle_cycles    = 0;
    src_calm       = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) send_request(DIRECTED[i]);
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % 40 == 0) src_calm = ($urandom_range(0, 3) == 0);
      send_request(pick_pattern());
    end
    din.valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("sent %0d requests (%0d directed); checked %0d characters, %0d out of range",
             reqs_sent, N_DIRECTED, chars_seen, oor_seen);
    $display("%0d mismatches or stray characters", errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
